FILE: src/pcm_decode_peak_energy_meter_assert.svh
// Assertion macros used by the meter's accumulate module.
`ifndef PCM_DECODE_PEAK_ENERGY_METER_ASSERT_SVH
`define PCM_DECODE_PEAK_ENERGY_METER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define PDPEM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define PDPEM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/pdpem_pkg.sv
package pdpem_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int SAMPLE_BITS        = 16;
   localparam int SQUARE_BITS        = 31;
   localparam int ENERGY_BITS        = 46;
   localparam int REPORT_BITS        = 16;
   localparam int CSR_ADDR_BITS      = 3;
   localparam int CSR_DATA_BITS      = 32;

   localparam logic [SAMPLE_BITS-1:0] INVERT_LOW_MASK = 16'h7FFF;
   localparam logic [SAMPLE_BITS-1:0] INVERT_SIGN_MASK = 16'h8000;
   localparam logic [SAMPLE_BITS-1:0] QUIET_LIMIT = 16'd16;
   localparam logic [ENERGY_BITS-1:0] ENERGY_MAX = '1;
   localparam logic [REPORT_BITS-1:0] REPORT_MAX = '1;

   typedef enum logic {
      REG_EIGHT_BIT_MODE = 1'b0,
      REG_INVERT_CONTROL = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic       eight_bit_mode;
      logic [1:0] invert_control;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] pattern;
      logic [SAMPLE_BITS-1:0] magnitude;
      logic [SQUARE_BITS-1:0] square;
      logic                   last;
   } sample_type;

endpackage

FILE: src/pcm_decode_peak_energy_meter.sv
// PCM sample decoder with run peak and energy meter. Each item carries one
// stored sample as two bytes; it is decoded per the CSR mode (signed 8-bit
// or big-endian 16-bit, then optional XOR with 0x7FFF and/or 0x8000) and
// returned as a signed 16-bit sample, one result per item. The item marked
// last also reports the run's peak magnitude, exact saturating sum of
// squares, sample count, quiet prefix count and a silent flag, and clears the
// run. Throughput is one item per clock while the result side is ready; a
// result reaches the outputs through the input register, the decode and
// square register, and the accumulate and result register. A stall on the
// result side fills the empty stages before it holds the input.
// Write the CSRs only while no item is in flight.
module pcm_decode_peak_energy_meter #(
   parameter int COUNT_BITS = pdpem_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [7:0]                              req_high_byte,
   input  logic [7:0]                              req_low_byte,
   input  logic                                    req_last_sample,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [pdpem_pkg::SAMPLE_BITS-1:0] rsp_decoded_sample,
   output logic                                    rsp_stats_valid,
   output logic [pdpem_pkg::SAMPLE_BITS-1:0]       rsp_peak_level,
   output logic [pdpem_pkg::ENERGY_BITS-1:0]       rsp_energy_total,
   output logic [pdpem_pkg::REPORT_BITS-1:0]       rsp_run_length,
   output logic [pdpem_pkg::REPORT_BITS-1:0]       rsp_quiet_prefix,
   output logic                                    rsp_silent_run,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [pdpem_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [pdpem_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [pdpem_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                    csr_pready
);
   import pdpem_pkg::*;

   cfg_type    cfg;
   logic       smp_valid;
   logic       smp_ready;
   sample_type smp;

   pdpem_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pdpem_decode u_decode (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_high_byte   (req_high_byte),
      .req_low_byte    (req_low_byte),
      .req_last_sample (req_last_sample),
      .smp_valid       (smp_valid),
      .smp_ready       (smp_ready),
      .smp             (smp)
   );

   pdpem_accum #(
      .COUNT_BITS (COUNT_BITS)
   ) u_accum (
      .clock              (clock),
      .reset              (reset),
      .smp_valid          (smp_valid),
      .smp_ready          (smp_ready),
      .smp                (smp),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_decoded_sample (rsp_decoded_sample),
      .rsp_stats_valid    (rsp_stats_valid),
      .rsp_peak_level     (rsp_peak_level),
      .rsp_energy_total   (rsp_energy_total),
      .rsp_run_length     (rsp_run_length),
      .rsp_quiet_prefix   (rsp_quiet_prefix),
      .rsp_silent_run     (rsp_silent_run)
   );

endmodule

FILE: src/pdpem_csr.sv
module pdpem_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [pdpem_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [pdpem_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [pdpem_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                  csr_pready,
   output pdpem_pkg::cfg_type                    cfg
);
   import pdpem_pkg::*;

   logic          eight_bit_mode_ff;
   logic [1:0]    invert_control_ff;
   reg_index_type reg_index;
   logic          write_en;

   assign reg_index  = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eight_bit_mode_ff <= 1'b0;
         invert_control_ff <= 2'b00;
      end else if (write_en) begin
         unique case (reg_index)
            REG_EIGHT_BIT_MODE: eight_bit_mode_ff <= csr_pwdata[0];
            REG_INVERT_CONTROL: invert_control_ff <= csr_pwdata[1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_EIGHT_BIT_MODE: csr_prdata = {{(CSR_DATA_BITS-1){1'b0}}, eight_bit_mode_ff};
         REG_INVERT_CONTROL: csr_prdata = {{(CSR_DATA_BITS-2){1'b0}}, invert_control_ff};
      endcase
   end

   assign cfg.eight_bit_mode = eight_bit_mode_ff;
   assign cfg.invert_control = invert_control_ff;

endmodule

FILE: src/pdpem_decode.sv
module pdpem_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  pdpem_pkg::cfg_type     cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_high_byte,
   input  logic [7:0]             req_low_byte,
   input  logic                   req_last_sample,
   output logic                   smp_valid,
   input  logic                   smp_ready,
   output pdpem_pkg::sample_type  smp
);
   import pdpem_pkg::*;

   logic                   in_valid_ff;
   logic [7:0]             in_high_ff;
   logic [7:0]             in_low_ff;
   logic                   in_last_ff;
   logic                   smp_valid_ff;
   sample_type             smp_ff;
   sample_type             smp_in;
   logic                   stage_ready;
   logic                   in_ready;
   logic [SAMPLE_BITS-1:0] pattern;
   logic [31:0]            product;

   assign stage_ready = !smp_valid_ff || smp_ready;
   assign in_ready    = !in_valid_ff || stage_ready;
   assign req_ready   = in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && in_ready) begin
         in_high_ff <= req_high_byte;
         in_low_ff  <= req_low_byte;
         in_last_ff <= req_last_sample;
      end
   end

   always_comb begin
      pattern = cfg.eight_bit_mode ? {in_high_ff, 8'h00} : {in_high_ff, in_low_ff};
      if (cfg.invert_control[0]) begin
         pattern = pattern ^ INVERT_LOW_MASK;
      end
      if (cfg.invert_control[1]) begin
         pattern = pattern ^ INVERT_SIGN_MASK;
      end
      smp_in.pattern   = pattern;
      smp_in.magnitude = pattern[SAMPLE_BITS-1] ? (~pattern + 1'b1) : pattern;
      product          = 32'(smp_in.magnitude) * 32'(smp_in.magnitude);
      smp_in.square    = product[SQUARE_BITS-1:0];
      smp_in.last      = in_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff <= 1'b0;
      end else if (stage_ready) begin
         smp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff && stage_ready) begin
         smp_ff <= smp_in;
      end
   end

   assign smp_valid = smp_valid_ff;
   assign smp       = smp_ff;

endmodule

FILE: src/pdpem_accum.sv
`include "pcm_decode_peak_energy_meter_assert.svh"

module pdpem_accum #(
   parameter int COUNT_BITS = pdpem_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    smp_valid,
   output logic                                    smp_ready,
   input  pdpem_pkg::sample_type                   smp,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [pdpem_pkg::SAMPLE_BITS-1:0] rsp_decoded_sample,
   output logic                                    rsp_stats_valid,
   output logic [pdpem_pkg::SAMPLE_BITS-1:0]       rsp_peak_level,
   output logic [pdpem_pkg::ENERGY_BITS-1:0]       rsp_energy_total,
   output logic [pdpem_pkg::REPORT_BITS-1:0]       rsp_run_length,
   output logic [pdpem_pkg::REPORT_BITS-1:0]       rsp_quiet_prefix,
   output logic                                    rsp_silent_run
);
   import pdpem_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam int WIDE_BITS = COUNT_BITS + REPORT_BITS;

   logic [SAMPLE_BITS-1:0] peak_ff, peak_in, peak_next;
   logic [ENERGY_BITS-1:0] energy_ff, energy_in, energy_next;
   logic [ENERGY_BITS:0]   energy_sum;
   logic [COUNT_BITS-1:0]  count_ff, count_in, count_next;
   logic [COUNT_BITS-1:0]  prefix_ff, prefix_in, prefix_next;
   logic                   in_prefix_ff, in_prefix_in, in_prefix_next;
   logic                   quiet;
   logic [WIDE_BITS-1:0]   count_wide, prefix_wide;
   logic [REPORT_BITS-1:0] run_report, prefix_report;

   logic                   rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] rsp_decoded_ff;
   logic                   rsp_stats_ff;
   logic [SAMPLE_BITS-1:0] rsp_peak_ff;
   logic [ENERGY_BITS-1:0] rsp_energy_ff;
   logic [REPORT_BITS-1:0] rsp_run_ff;
   logic [REPORT_BITS-1:0] rsp_quiet_ff;
   logic                   rsp_silent_ff;
   logic                   out_ready;
   logic                   fire;

   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign smp_ready = out_ready;
   assign fire      = smp_valid && out_ready;

   always_comb begin
      peak_next      = (smp.magnitude > peak_ff) ? smp.magnitude : peak_ff;
      energy_sum     = {1'b0, energy_ff} + (ENERGY_BITS+1)'(smp.square);
      energy_next    = energy_sum[ENERGY_BITS] ? ENERGY_MAX : energy_sum[ENERGY_BITS-1:0];
      count_next     = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
      quiet          = smp.magnitude < QUIET_LIMIT;
      in_prefix_next = in_prefix_ff && quiet;
      prefix_next    = (in_prefix_next && prefix_ff != COUNT_MAX) ? prefix_ff + 1'b1
                                                                  : prefix_ff;
      count_wide     = WIDE_BITS'(count_next);
      prefix_wide    = WIDE_BITS'(prefix_next);
      run_report     = (count_wide > WIDE_BITS'(REPORT_MAX)) ? REPORT_MAX
                                                              : count_wide[REPORT_BITS-1:0];
      prefix_report  = (prefix_wide > WIDE_BITS'(REPORT_MAX)) ? REPORT_MAX
                                                               : prefix_wide[REPORT_BITS-1:0];
      if (smp.last) begin
         peak_in      = '0;
         energy_in    = '0;
         count_in     = '0;
         prefix_in    = '0;
         in_prefix_in = 1'b1;
      end else begin
         peak_in      = peak_next;
         energy_in    = energy_next;
         count_in     = count_next;
         prefix_in    = prefix_next;
         in_prefix_in = in_prefix_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff      <= '0;
         energy_ff    <= '0;
         count_ff     <= '0;
         prefix_ff    <= '0;
         in_prefix_ff <= 1'b1;
      end else if (fire) begin
         peak_ff      <= peak_in;
         energy_ff    <= energy_in;
         count_ff     <= count_in;
         prefix_ff    <= prefix_in;
         in_prefix_ff <= in_prefix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= smp_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_decoded_ff <= smp.pattern;
         rsp_stats_ff   <= smp.last;
         rsp_peak_ff    <= smp.last ? peak_next : '0;
         rsp_energy_ff  <= smp.last ? energy_next : '0;
         rsp_run_ff     <= smp.last ? run_report : '0;
         rsp_quiet_ff   <= smp.last ? prefix_report : '0;
         rsp_silent_ff  <= smp.last && (peak_next == '0);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_decoded_sample = $signed(rsp_decoded_ff);
   assign rsp_stats_valid    = rsp_stats_ff;
   assign rsp_peak_level     = rsp_peak_ff;
   assign rsp_energy_total   = rsp_energy_ff;
   assign rsp_run_length     = rsp_run_ff;
   assign rsp_quiet_prefix   = rsp_quiet_ff;
   assign rsp_silent_run     = rsp_silent_ff;

   `PDPEM_ASSERT_IMPLY(a_stats_zero_mid_run, clock, reset, rsp_valid_ff && !rsp_stats_ff, rsp_peak_ff == '0 && rsp_energy_ff == '0 && rsp_run_ff == '0 && rsp_quiet_ff == '0 && !rsp_silent_ff, "statistics nonzero on an item that does not close a run")
   `PDPEM_ASSERT_IMPLY(a_silent_peak, clock, reset, rsp_valid_ff && rsp_silent_ff, rsp_stats_ff && rsp_peak_ff == '0, "silent run flagged with nonzero peak")
   `PDPEM_ASSERT_IMPLY(a_prefix_in_run, clock, reset, rsp_valid_ff && rsp_stats_ff, rsp_run_ff != '0 && rsp_quiet_ff <= rsp_run_ff, "quiet prefix exceeds run length")
   `PDPEM_ASSERT_NEXT(a_clear_after_last, clock, reset, fire && smp.last, peak_ff == '0 && energy_ff == '0 && count_ff == '0 && prefix_ff == '0 && in_prefix_ff, "run state not cleared after last item")
   `PDPEM_ASSERT_NEXT(a_prefix_closed, clock, reset, !in_prefix_ff && !(fire && smp.last), $stable(prefix_ff) && !in_prefix_ff, "quiet prefix moved after it ended")

endmodule

FILE: tb/pcm_meter_checker.sv
`timescale 1ns / 100ps

module pcm_meter_checker #(
   parameter int COUNT_BITS = pdpem_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic                                     req_ready,
   input  logic [7:0]                               req_high_byte,
   input  logic [7:0]                               req_low_byte,
   input  logic                                     req_last_sample,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   input  logic signed [pdpem_pkg::SAMPLE_BITS-1:0] rsp_decoded_sample,
   input  logic                                     rsp_stats_valid,
   input  logic [pdpem_pkg::SAMPLE_BITS-1:0]        rsp_peak_level,
   input  logic [pdpem_pkg::ENERGY_BITS-1:0]        rsp_energy_total,
   input  logic [pdpem_pkg::REPORT_BITS-1:0]        rsp_run_length,
   input  logic [pdpem_pkg::REPORT_BITS-1:0]        rsp_quiet_prefix,
   input  logic                                     rsp_silent_run,
   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [pdpem_pkg::CSR_ADDR_BITS-1:0]      csr_paddr,
   input  logic [pdpem_pkg::CSR_DATA_BITS-1:0]      csr_pwdata,
   input  logic [pdpem_pkg::CSR_DATA_BITS-1:0]      csr_prdata,
   input  logic                                     csr_pready,
   output int                                       errors,
   output int                                       pending
);
   import pdpem_pkg::*;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          stats;
      logic [SAMPLE_BITS-1:0]        peak;
      logic [ENERGY_BITS-1:0]        energy;
      logic [REPORT_BITS-1:0]        run_len;
      logic [REPORT_BITS-1:0]        quiet_len;
      logic                          silent;
   } meter_report_type;

   cfg_type                meter_cfg;
   logic [SAMPLE_BITS-1:0] run_peak;
   logic [ENERGY_BITS:0]   run_energy;
   logic [COUNT_BITS-1:0]  run_count;
   logic [COUNT_BITS-1:0]  quiet_count;
   logic                   quiet_open;
   meter_report_type       expected_reports[$];
   meter_report_type       fresh;
   meter_report_type       want;
   reg_index_type          csr_index;
   logic [CSR_DATA_BITS-1:0] csr_expect;
   int                     mismatch_count = 0;
   int                     pending_count = 0;
   int                     result_index = 0;

   assign errors  = mismatch_count;
   assign pending = pending_count;

   function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
      return (&c) ? c : c + 1'b1;
   endfunction

   function automatic logic [REPORT_BITS-1:0] clip_report(input logic [COUNT_BITS-1:0] c);
      return (c > REPORT_MAX) ? REPORT_MAX : REPORT_BITS'(c);
   endfunction

   task automatic clear_run();
      run_peak    = '0;
      run_energy  = '0;
      run_count   = '0;
      quiet_count = '0;
      quiet_open  = 1'b1;
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint exp_val);
      if (mismatch_count < 100) begin
         $display("%0t: result %0d %s got %0d expected %0d",
                  $time, result_index, what, got, exp_val);
      end
      mismatch_count++;
   endtask

   task automatic meter_sample(input logic [7:0] hi, input logic [7:0] lo, input logic last,
                               output meter_report_type r);
      logic [SAMPLE_BITS-1:0] pat;
      logic [SAMPLE_BITS:0]   mag;
      logic [ENERGY_BITS:0]   square;
      pat = meter_cfg.eight_bit_mode ? {hi, 8'h00} : {hi, lo};
      if (meter_cfg.invert_control[0]) pat ^= INVERT_LOW_MASK;
      if (meter_cfg.invert_control[1]) pat ^= INVERT_SIGN_MASK;
      mag = pat[SAMPLE_BITS-1] ? ({1'b1, {SAMPLE_BITS{1'b0}}} - {1'b0, pat}) : {1'b0, pat};
      if (mag > run_peak) run_peak = mag[SAMPLE_BITS-1:0];
      square = mag * mag;
      if (run_energy + square > ENERGY_MAX) begin
         run_energy = ENERGY_MAX;
      end else begin
         run_energy = run_energy + square;
      end
      run_count = bump(run_count);
      if (quiet_open && mag < QUIET_LIMIT) begin
         quiet_count = bump(quiet_count);
      end else begin
         quiet_open = 1'b0;
      end
      r = '0;
      r.sample = pat;
      if (last) begin
         r.stats     = 1'b1;
         r.peak      = run_peak;
         r.energy    = run_energy[ENERGY_BITS-1:0];
         r.run_len   = clip_report(run_count);
         r.quiet_len = clip_report(quiet_count);
         r.silent    = (run_peak == '0);
         clear_run();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         meter_cfg = '0;
         clear_run();
         expected_reports.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            csr_index = reg_index_type'(csr_paddr[2]);
            if (csr_pwrite) begin
               case (csr_index)
                  REG_EIGHT_BIT_MODE: meter_cfg.eight_bit_mode = csr_pwdata[0];
                  REG_INVERT_CONTROL: meter_cfg.invert_control = csr_pwdata[1:0];
               endcase
            end else begin
               case (csr_index)
                  REG_EIGHT_BIT_MODE: csr_expect = CSR_DATA_BITS'(meter_cfg.eight_bit_mode);
                  default:            csr_expect = CSR_DATA_BITS'(meter_cfg.invert_control);
               endcase
               if (csr_prdata !== csr_expect) begin
                  report_mismatch("csr read", csr_prdata, csr_expect);
               end
            end
         end
         if (req_valid && req_ready) begin
            meter_sample(req_high_byte, req_low_byte, req_last_sample, fresh);
            expected_reports.push_back(fresh);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               report_mismatch("unexpected, decoded_sample", rsp_decoded_sample, 0);
            end else begin
               want = expected_reports.pop_front();
               if (rsp_decoded_sample !== want.sample)
                  report_mismatch("decoded_sample", rsp_decoded_sample, want.sample);
               if (rsp_stats_valid !== want.stats)
                  report_mismatch("stats_valid", rsp_stats_valid, want.stats);
               if (rsp_peak_level !== want.peak)
                  report_mismatch("peak_level", rsp_peak_level, want.peak);
               if (rsp_energy_total !== want.energy)
                  report_mismatch("energy_total", rsp_energy_total, want.energy);
               if (rsp_run_length !== want.run_len)
                  report_mismatch("run_length", rsp_run_length, want.run_len);
               if (rsp_quiet_prefix !== want.quiet_len)
                  report_mismatch("quiet_prefix", rsp_quiet_prefix, want.quiet_len);
               if (rsp_silent_run !== want.silent)
                  report_mismatch("silent_run", rsp_silent_run, want.silent);
            end
            result_index++;
         end
      end
      pending_count = expected_reports.size();
   end

endmodule

FILE: tb/pcm_decode_peak_energy_meter_tb.sv
`timescale 1ns / 100ps

module pcm_decode_peak_energy_meter_tb;
   import pdpem_pkg::*;

   localparam int CYCLE_LIMIT  = 200_000;
   localparam int RANDOM_ITEMS = 640;
   localparam int PHASES       = 8;
   localparam int PEAK_RUN     = 8;
   localparam int QUIET_RUN    = 24;

   localparam logic       PHASE_MODE[PHASES]   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
   localparam logic [1:0] PHASE_INVERT[PHASES] = '{2'd0, 2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd2, 2'd1};
   localparam logic [15:0] EDGE_SAMPLES[6] =
      '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h8001, 16'h0010};
   localparam logic [16:0] DIRECTED_WIDE[16] = '{
      {16'h0000, 1'b1}, {16'h8000, 1'b1},
      {16'h0000, 1'b0}, {16'h000F, 1'b0}, {16'hFFF1, 1'b0}, {16'h0010, 1'b0},
      {16'h0005, 1'b0}, {16'h7FFF, 1'b0}, {16'hFFFF, 1'b0}, {16'hFFF0, 1'b1},
      {16'h00FF, 1'b0}, {16'hA55A, 1'b0}, {16'h5AA5, 1'b1},
      {16'h0000, 1'b0}, {16'h0000, 1'b0}, {16'h0000, 1'b1}
   };
   localparam logic [16:0] DIRECTED_NARROW[5] = '{
      {16'h80FF, 1'b0}, {16'h7F00, 1'b0}, {16'h01AA, 1'b0}, {16'hFF55, 1'b1},
      {16'h00FF, 1'b1}
   };

   typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_STALLS} rx_pattern_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [7:0]                      req_high_byte = '0;
   logic [7:0]                      req_low_byte = '0;
   logic                            req_last_sample = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic signed [SAMPLE_BITS-1:0]   rsp_decoded_sample;
   logic                            rsp_stats_valid;
   logic [SAMPLE_BITS-1:0]          rsp_peak_level;
   logic [ENERGY_BITS-1:0]          rsp_energy_total;
   logic [REPORT_BITS-1:0]          rsp_run_length;
   logic [REPORT_BITS-1:0]          rsp_quiet_prefix;
   logic                            rsp_silent_run;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]        csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0]        csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0]        csr_prdata;
   logic                            csr_pready;

   int             errors;
   int             pending;
   int             cycles = 0;
   int             burst_left = 0;
   int             run_left = 0;
   int             quiet_left = 0;
   logic           run_silent = 1'b0;
   cfg_type        stim_cfg = '0;
   rx_pattern_type rx_mode = RX_OPEN;
   int             rx_left = 0;
   int             rx_tick = 0;
   int             rx_hold = 0;

   pcm_decode_peak_energy_meter uut (.*);

   pcm_meter_checker u_checker (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_pattern_type'($urandom_range(0, 3));
         rx_left = $urandom_range(16, 200);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
         RX_OPEN:   rsp_ready <= 1'b1;
         RX_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_ready <= (rx_tick % 4) == 0;
         default: begin
            if (rx_hold == 0 && $urandom_range(0, 15) == 0) rx_hold = $urandom_range(4, 24);
            if (rx_hold != 0) rx_hold--;
            rsp_ready <= (rx_hold == 0);
         end
      endcase
   end

   task automatic send_sample(input logic [7:0] hi, input logic [7:0] lo, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_high_byte   <= hi;
      req_low_byte    <= lo;
      req_last_sample <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Map the wanted decoded value back to the stored bytes.
   task automatic send_target(input logic [15:0] target, input logic last);
      logic [15:0] raw;
      raw = target;
      if (stim_cfg.invert_control[0]) raw ^= INVERT_LOW_MASK;
      if (stim_cfg.invert_control[1]) raw ^= INVERT_SIGN_MASK;
      send_sample(raw[15:8], stim_cfg.eight_bit_mode ? 8'($urandom) : raw[7:0], last);
   endtask

   task automatic csr_access(input reg_index_type idx, input logic write,
                             input logic [CSR_DATA_BITS-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic apply_config(input logic mode, input logic [1:0] inv);
      drain();
      csr_access(REG_EIGHT_BIT_MODE, 1'b1, CSR_DATA_BITS'(mode));
      csr_access(REG_INVERT_CONTROL, 1'b1, CSR_DATA_BITS'(inv));
      csr_access(REG_EIGHT_BIT_MODE, 1'b0, '0);
      csr_access(REG_INVERT_CONTROL, 1'b0, '0);
      stim_cfg = {mode, inv};
   endtask

   task automatic random_items(input int count);
      logic [15:0] target;
      for (int n = 0; n < count; n++) begin
         if (run_left == 0) begin
            case ($urandom_range(0, 9))
               0:       run_left = 1;
               1, 2:    run_left = $urandom_range(17, 60);
               default: run_left = $urandom_range(2, 16);
            endcase
            quiet_left = $urandom_range(0, run_left);
            run_silent = ($urandom_range(0, 19) == 0);
         end
         if (run_silent) begin
            target = '0;
         end else if (quiet_left != 0) begin
            target = 16'($urandom_range(0, 15));
            quiet_left--;
         end else begin
            case ($urandom_range(0, 4))
               0:       target = EDGE_SAMPLES[$urandom_range(0, 5)];
               1:       target = 16'($urandom_range(0, 40));
               default: target = 16'($urandom);
            endcase
         end
         if (target < 16'd64 && $urandom_range(0, 1) == 1) target = -target;
         run_left--;
         send_target(target, run_left == 0);
      end
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      apply_config(1'b0, 2'd0);
      foreach (DIRECTED_WIDE[i]) begin
         send_sample(DIRECTED_WIDE[i][16:9], DIRECTED_WIDE[i][8:1], DIRECTED_WIDE[i][0]);
      end

      // full-scale run, then a quiet prefix ended by a loud sample
      for (int n = 0; n < PEAK_RUN; n++) send_target(16'h8000, n == PEAK_RUN - 1);
      for (int n = 0; n < QUIET_RUN; n++) begin
         send_target(($urandom_range(0, 1) == 1) ? -16'($urandom_range(0, 15))
                                                 : 16'($urandom_range(0, 15)), 1'b0);
      end
      send_target(16'h0400, 1'b0);
      send_target(16'h0003, 1'b0);
      send_target(16'h0000, 1'b1);

      apply_config(1'b1, 2'd0);
      foreach (DIRECTED_NARROW[i]) begin
         send_sample(DIRECTED_NARROW[i][16:9], DIRECTED_NARROW[i][8:1], DIRECTED_NARROW[i][0]);
      end

      for (int p = 0; p < PHASES; p++) begin
         apply_config(PHASE_MODE[p], PHASE_INVERT[p]);
         random_items(RANDOM_ITEMS / PHASES);
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
